@@ rtl/core/rhc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and fixed widths for the RGB/HSL colour converter.
// No dependencies; the datapaths, the top level and the testbench import this package.
package rhc_pkg;

  localparam int IN_W         = 20;  // signed S3.16 input component
  localparam int OUT_W        = 17;  // unsigned 1.16 output component
  localparam int IN_TDATA_W   = 64;  // three input components, byte padded
  localparam int OUT_TDATA_W  = 56;  // three output components, byte padded
  localparam int OUT_FIELDS_W = 3 * OUT_W;

  typedef enum logic {
    DIR_RGB2HSL = 1'b0,
    DIR_HSL2RGB = 1'b1
  } dir_t;

  typedef logic signed [IN_W-1:0] comp_in_t;
  typedef logic [OUT_W-1:0]       comp_out_t;

endpackage

@@ rtl/core/rhc_dly.sv @@
`timescale 1ns / 1ps
// Enabled shift line that carries side data alongside a pipelined unit.
// Standalone; no package needed.
module rhc_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
    end
  end

  for (genvar i = 1; i < N; i++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule

@@ rtl/core/rhc_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// Caller guarantees num >> QW is below den. Standalone; no package needed.
module rhc_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] lo_r  [QW];
  logic [QW-1:0] q_r   [QW];
  logic [DW-1:0] den_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_i;
    logic [QW-1:0] lo_i;
    logic [QW-1:0] q_i;
    logic [DW-1:0] den_i;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    if (i == 0) begin : g_first
      assign rem_i = DW'(num >> QW);
      assign lo_i  = num[QW-1:0];
      assign q_i   = '0;
      assign den_i = den;
    end else begin : g_next
      assign rem_i = rem_r[i-1];
      assign lo_i  = lo_r[i-1];
      assign q_i   = q_r[i-1];
      assign den_i = den_r[i-1];
    end

    assign trial   = {rem_i, lo_i[QW-1]};
    assign ge      = trial >= {1'b0, den_i};
    assign rem_nxt = ge ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        lo_r[i]  <= {lo_i[QW-2:0], 1'b0};
        q_r[i]   <= {q_i[QW-2:0], ge};
        den_r[i] <= den_i;
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

@@ rtl/core/rhc_to_hsl.sv @@
`timescale 1ns / 1ps
// RGB to HSL datapath: max scaling, min/max, saturation and hue division.
// Uses rhc_pkg, rhc_div and rhc_dly.
module rhc_to_hsl #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              en,
  input  rhc_pkg::comp_in_t r_in,
  input  rhc_pkg::comp_in_t g_in,
  input  rhc_pkg::comp_in_t b_in,
  output rhc_pkg::comp_out_t h_out,
  output rhc_pkg::comp_out_t s_out,
  output rhc_pkg::comp_out_t l_out
);
  import rhc_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int PV  = IN_W - 1;
  localparam int CW  = F + 1;
  localparam int BW  = (IN_W > F + 2) ? IN_W : F + 2;
  localparam int NMW = CW + 4;
  localparam int NSW = CW + F + 2;
  localparam int NHW = CW + F + 5;
  localparam logic signed [BW-1:0] ONE_B = {{(BW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic [CW:0]   ONE_S = {2'b01, {F{1'b0}}};
  localparam logic [CW:0]   TWO_S = {2'b10, {F{1'b0}}};
  localparam logic [CW-1:0] ONE_C = {1'b1, {F{1'b0}}};
  localparam logic [1:0] MAX_R = 2'd0;
  localparam logic [1:0] MAX_G = 2'd1;
  localparam logic [1:0] MAX_B = 2'd2;

  // stage 1: clip negatives, find the scale divisor
  comp_in_t mx3;
  logic signed [BW-1:0] mxw;
  logic [PV-1:0] pos_r [3];
  logic [PV-1:0] mx_r;
  logic          big_r;

  always_comb begin
    mx3 = (r_in > g_in) ? r_in : g_in;
    mx3 = (mx3 > b_in) ? mx3 : b_in;
    mxw = BW'(mx3);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r[0] <= r_in[IN_W-1] ? '0 : r_in[PV-1:0];
      pos_r[1] <= g_in[IN_W-1] ? '0 : g_in[PV-1:0];
      pos_r[2] <= b_in[IN_W-1] ? '0 : b_in[PV-1:0];
      mx_r     <= mx3[PV-1:0];
      big_r    <= mxw > ONE_B;
    end
  end

  // scale by the largest component, truncating
  logic [CW-1:0] qa [3];
  logic [PV-1:0] pos_d [3];
  logic          big_d;

  for (genvar k = 0; k < 3; k++) begin : g_scale
    rhc_div #(.NW(PV + F), .DW(PV), .QW(CW)) u_div (
      .clk (clk),
      .en  (en),
      .num ({pos_r[k], {F{1'b0}}}),
      .den (mx_r),
      .quo (qa[k])
    );
  end

  rhc_dly #(.W(3 * PV + 1), .N(CW)) u_dly_a (
    .clk (clk),
    .en  (en),
    .d   ({big_r, pos_r[2], pos_r[1], pos_r[0]}),
    .q   ({big_d, pos_d[2], pos_d[1], pos_d[0]})
  );

  // stage 2: pick scaled or plain components, min and max
  logic [CW-1:0] cs [3];
  logic [CW-1:0] mx2, mn2;
  logic [1:0]    msel;
  logic [CW-1:0] c_r [3];
  logic [CW-1:0] mx_2r, mn_2r;
  logic [1:0]    msel_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cs[k] = big_d ? qa[k] : CW'(pos_d[k]);
    end
    mx2 = (cs[0] > cs[1]) ? cs[0] : cs[1];
    mx2 = (mx2 > cs[2]) ? mx2 : cs[2];
    mn2 = (cs[0] < cs[1]) ? cs[0] : cs[1];
    mn2 = (mn2 < cs[2]) ? mn2 : cs[2];
    if (mx2 == cs[0]) begin
      msel = MAX_R;
    end else if (mx2 == cs[1]) begin
      msel = MAX_G;
    end else begin
      msel = MAX_B;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r    <= cs;
      mx_2r  <= mx2;
      mn_2r  <= mn2;
      msel_r <= msel;
    end
  end

  // stage 3: lightness and the two dividends
  logic [CW-1:0]  diff;
  logic [CW:0]    sum;
  logic [CW-1:0]  lgt;
  logic [CW:0]    den_s;
  logic signed [NMW-1:0] dfs, rs, gs, bs, num;
  logic [CW+2:0]  diff6;
  logic [NSW-1:0] num_s_r;
  logic [CW+1:0]  den_s_r;
  logic [NHW-1:0] num_h_r;
  logic [CW+3:0]  den_h_r;
  logic [CW-1:0]  l_3r;
  logic           grey_3r;

  always_comb begin
    diff  = mx_2r - mn_2r;
    sum   = {1'b0, mx_2r} + {1'b0, mn_2r};
    lgt   = CW'((sum + (CW+1)'(1)) >> 1);
    den_s = (sum < ONE_S) ? sum : TWO_S - sum;
    dfs   = $signed(NMW'(diff));
    rs    = $signed(NMW'(c_r[0]));
    gs    = $signed(NMW'(c_r[1]));
    bs    = $signed(NMW'(c_r[2]));
    case (msel_r)
      MAX_R:   num = gs - bs;
      MAX_G:   num = (dfs <<< 1) + bs - rs;
      default: num = (dfs <<< 2) + rs - gs;
    endcase
    if (num < 0) begin
      num = num + (dfs <<< 2) + (dfs <<< 1);
    end
    diff6 = (CW+3)'({diff, 2'b00}) + (CW+3)'({diff, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_s_r <= NSW'({diff, {(F+1){1'b0}}}) + NSW'(den_s);
      den_s_r <= {den_s, 1'b0};
      num_h_r <= NHW'({num[CW+2:0], {(F+1){1'b0}}}) + NHW'(diff6);
      den_h_r <= {diff6, 1'b0};
      l_3r    <= lgt;
      grey_3r <= mx_2r == mn_2r;
    end
  end

  // saturation and hue, rounded to nearest
  logic [CW-1:0] sq, hq, l_d;
  logic          grey_d;

  rhc_div #(.NW(NSW), .DW(CW + 2), .QW(CW)) u_div_s (
    .clk (clk),
    .en  (en),
    .num (num_s_r),
    .den (den_s_r),
    .quo (sq)
  );

  rhc_div #(.NW(NHW), .DW(CW + 4), .QW(CW)) u_div_h (
    .clk (clk),
    .en  (en),
    .num (num_h_r),
    .den (den_h_r),
    .quo (hq)
  );

  rhc_dly #(.W(CW + 1), .N(CW)) u_dly_b (
    .clk (clk),
    .en  (en),
    .d   ({grey_3r, l_3r}),
    .q   ({grey_d, l_d})
  );

  // final stage: wrap a hue of one, zero hue and saturation on grey
  logic [CW-1:0] h_r, s_r, l_r;

  always_ff @(posedge clk) begin
    if (en) begin
      h_r <= (grey_d || hq == ONE_C) ? '0 : hq;
      s_r <= grey_d ? '0 : sq;
      l_r <= l_d;
    end
  end

  assign h_out = OUT_W'(h_r);
  assign s_out = OUT_W'(s_r);
  assign l_out = OUT_W'(l_r);

endmodule

@@ rtl/core/rhc_to_rgb.sv @@
`timescale 1ns / 1ps
// HSL to RGB datapath: hue wrap, t1/t2 terms, three channel ramps.
// Uses rhc_pkg.
module rhc_to_rgb #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  rhc_pkg::comp_in_t  h_in,
  input  rhc_pkg::comp_in_t  s_in,
  input  rhc_pkg::comp_in_t  l_in,
  output rhc_pkg::comp_out_t r_out,
  output rhc_pkg::comp_out_t g_out,
  output rhc_pkg::comp_out_t b_out
);
  import rhc_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int HXW = (IN_W > F) ? IN_W : F;
  localparam int SW  = ((IN_W > F + 1) ? IN_W : F + 1) + 1;
  localparam int BW  = SW + 1;
  localparam int PW  = IN_W + SW;
  localparam int TW  = PW - F + 3;
  localparam int FW  = F + 2;
  localparam int MW  = TW + 1 + FW;
  localparam int VW  = MW - F + 1;
  localparam int V3W = F + 3;
  localparam logic signed [BW-1:0] ONE_B  = {{(BW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [SW-1:0] ONE_SW = {{(SW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [PW-1:0] HALF_P = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [MW-1:0] HALF_M = {{(MW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [VW-1:0] ONE_V  = {{(VW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic [V3W-1:0] ONE_3  = {3'b001, {F{1'b0}}};
  localparam logic [V3W-1:0] TWO_3  = {3'b010, {F{1'b0}}};
  localparam logic [V3W-1:0] THR_3  = {3'b011, {F{1'b0}}};
  localparam logic [1:0] SEG_RAMP = 2'd0;
  localparam logic [1:0] SEG_T1   = 2'd1;
  localparam logic [1:0] SEG_T2   = 2'd2;

  // stage 1: wrap hue, one multiply for t1
  logic signed [HXW-1:0] hx;
  logic signed [BW-1:0]  lw;
  logic                  lo;
  logic signed [SW-1:0]  fac;
  logic signed [PW-1:0]  prod_r;
  logic                  lo_r, sz_r;
  comp_in_t              l_r, s_r;
  logic [F-1:0]          hm_r;

  always_comb begin
    hx  = HXW'(h_in);
    lw  = BW'(l_in);
    lo  = (lw <<< 1) < ONE_B;
    fac = lo ? ONE_SW + SW'(s_in) : SW'(s_in);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PW'(l_in) * PW'(fac);
      lo_r   <= lo;
      sz_r   <= s_in == '0;
      l_r    <= l_in;
      s_r    <= s_in;
      hm_r   <= hx[F-1:0];
    end
  end

  // stage 2: t1, t2 and the three hue positions scaled by three
  logic signed [TW-1:0] rnd, t1, t2;
  logic [V3W-1:0] h3;
  logic [V3W-1:0] v3 [3];
  logic signed [TW-1:0] t1_r, t2_r;
  logic [V3W-1:0] v3_r [3];
  logic           sz_2r;
  comp_in_t       l_2r;

  always_comb begin
    rnd = TW'((prod_r + HALF_P) >>> F);
    t1  = lo_r ? rnd : TW'(l_r) + TW'(s_r) - rnd;
    t2  = (TW'(l_r) <<< 1) - t1;
    h3  = V3W'({hm_r, 1'b0}) + V3W'(hm_r);
    v3[0] = h3 + ONE_3;
    v3[1] = h3;
    v3[2] = h3 + TWO_3;
    for (int k = 0; k < 3; k++) begin
      if (v3[k] > THR_3) begin
        v3[k] = v3[k] - THR_3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= t1;
      t2_r  <= t2;
      v3_r  <= v3;
      sz_2r <= sz_r;
      l_2r  <= l_r;
    end
  end

  // stage 3: segment of the hue rule and the ramp product per channel
  logic signed [TW:0]   dlt;
  logic [V3W:0]         v2 [3];
  logic [1:0]           seg [3];
  logic signed [FW-1:0] rf [3];
  logic signed [MW-1:0] rp_r [3];
  logic [1:0]           seg_r [3];
  logic signed [TW-1:0] t1_3r, t2_3r;
  logic                 sz_3r;
  comp_in_t             l_3r;

  always_comb begin
    dlt = (TW+1)'(t1_r) - (TW+1)'(t2_r);
    for (int k = 0; k < 3; k++) begin
      v2[k] = {v3_r[k], 1'b0};
      rf[k] = '0;
      if (v2[k] < (V3W+1)'(ONE_3)) begin
        seg[k] = SEG_RAMP;
        rf[k]  = FW'(v2[k]);
      end else if (v2[k] < (V3W+1)'(THR_3)) begin
        seg[k] = SEG_T1;
      end else if (v3_r[k] < TWO_3) begin
        seg[k] = SEG_RAMP;
        rf[k]  = FW'({TWO_3 - v3_r[k], 1'b0});
      end else begin
        seg[k] = SEG_T2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rp_r[k]  <= MW'(dlt) * MW'(rf[k]);
        seg_r[k] <= seg[k];
      end
      t1_3r <= t1_r;
      t2_3r <= t2_r;
      sz_3r <= sz_2r;
      l_3r  <= l_2r;
    end
  end

  // stage 4: round the ramp, pick the channel, clamp to [0, one]
  logic signed [VW-1:0] val [3];
  logic [OUT_W-1:0]     ch_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (seg_r[k])
        SEG_RAMP: val[k] = VW'(t2_3r) + VW'((rp_r[k] + HALF_M) >>> F);
        SEG_T1:   val[k] = VW'(t1_3r);
        default:  val[k] = VW'(t2_3r);
      endcase
      if (sz_3r) begin
        val[k] = VW'(l_3r);
      end
      if (val[k] < 0) begin
        val[k] = '0;
      end else if (val[k] > ONE_V) begin
        val[k] = ONE_V;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ch_r[k] <= val[k][OUT_W-1:0];
      end
    end
  end

  assign r_out = ch_r[0];
  assign g_out = ch_r[1];
  assign b_out = ch_r[2];

endmodule

@@ rtl/core/rgb_hsl_colour_converter.sv @@
`timescale 1ns / 1ps
// Top level of the RGB/HSL colour converter: pipelines, valid line, output skid.
// Uses rhc_pkg, rhc_to_hsl, rhc_to_rgb and rhc_dly.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------
//  in_     | in  | in_tvalid / in_tready  | in_tdata: first, second, third S3.16
//  out_    | out | out_tvalid / out_tready| out_tdata: first, second, third 1.16
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_data: direction (0 RGB->HSL)
//
// One item per clock sustained while the output is not stalled. The delay is
// set by two pipelined restoring dividers of FRAC_BITS+1 stages each.
// Both directions run side by side; the HSL to RGB result is delayed to match.
// Reset (rst_n low, synchronous) clears valid bits, the output and skid valid
// and the direction register. A stall at the output is caught by a one-item
// skid register; the whole pipeline then holds until the skid drains.
module rgb_hsl_colour_converter #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [19:0] first_in, [39:20] second_in, [59:40] third_in, [63:60] zero
  input  logic [rhc_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [16:0] first_out, [33:17] second_out, [50:34] third_out, [55:51] zero
  output logic [rhc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data
);
  import rhc_pkg::*;

  localparam int LAT_HSL = 2 * FRAC_BITS + 6;
  localparam int LAT_RGB = 4;

  // configuration: always ready; to be written only while idle, not enforced here
  dir_t dir_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_RGB2HSL;
    end else if (cfg_valid) begin
      dir_r <= dir_t'(cfg_data);
    end
  end

  // pipeline advances whenever the skid register is free
  logic en;
  logic skid_v_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  comp_in_t f0, f1, f2;
  assign f0 = in_tdata[IN_W-1:0];
  assign f1 = in_tdata[2*IN_W-1:IN_W];
  assign f2 = in_tdata[3*IN_W-1:2*IN_W];

  comp_out_t hsl0, hsl1, hsl2, rgb0, rgb1, rgb2;
  logic [OUT_FIELDS_W-1:0] rgb_pad;

  rhc_to_hsl #(.FRAC_BITS(FRAC_BITS)) u_hsl (
    .clk   (clk),
    .en    (en),
    .r_in  (f0),
    .g_in  (f1),
    .b_in  (f2),
    .h_out (hsl0),
    .s_out (hsl1),
    .l_out (hsl2)
  );

  rhc_to_rgb #(.FRAC_BITS(FRAC_BITS)) u_rgb (
    .clk   (clk),
    .en    (en),
    .h_in  (f0),
    .s_in  (f1),
    .l_in  (f2),
    .r_out (rgb0),
    .g_out (rgb1),
    .b_out (rgb2)
  );

  // align the short path with the divider path
  rhc_dly #(.W(OUT_FIELDS_W), .N(LAT_HSL - LAT_RGB)) u_pad (
    .clk (clk),
    .en  (en),
    .d   ({rgb2, rgb1, rgb0}),
    .q   (rgb_pad)
  );

  // valid bits travel with the data
  logic [LAT_HSL-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT_HSL-2:0], in_tvalid};
    end
  end

  logic                    pipe_v;
  logic [OUT_FIELDS_W-1:0] pipe_d;

  assign pipe_v = vld_r[LAT_HSL-1] && en;
  assign pipe_d = (dir_r == DIR_HSL2RGB) ? rgb_pad : {hsl2, hsl1, hsl0};

  // output register plus one skid entry
  logic                    out_v_r;
  logic [OUT_FIELDS_W-1:0] out_d_r, skid_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        // drain the skid first; the pipeline is held meanwhile
        if (out_tready) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end
      end else if (!out_v_r || out_tready) begin
        out_v_r <= pipe_v;
      end else if (pipe_v) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_d_r <= skid_d_r;
      end
    end else if (!out_v_r || out_tready) begin
      if (pipe_v) begin
        out_d_r <= pipe_d;
      end
    end else if (pipe_v) begin
      skid_d_r <= pipe_d;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_TDATA_W'(out_d_r);

endmodule

@@ rtl/core/rhc_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for the colour converter, bound to the top level.
// Depends only on the top-level ports.
module rhc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // reset leaves no result on the output
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // input stalls only while a result is waiting at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

endmodule

bind rgb_hsl_colour_converter rhc_chk u_rhc_chk (.*);

@@ tb/sv/rhc_checker.sv @@
`timescale 1ns / 1ps
// Checker for the RGB/HSL colour converter: watches the input, output and
// configuration channels, predicts each pixel and compares. Uses rhc_pkg.
module rhc_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [rhc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [rhc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic                            cfg_data,
  output int                              err_count,
  output int                              pending
);
  import rhc_pkg::*;

  localparam longint ONE = 64'sd1 << 16;

  dir_t               cur_dir;
  logic [OUT_W*3-1:0] pixel_q[$];

  function automatic longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint rnd_div(longint a, longint d);
    return fdiv(2 * a + d, 2 * d);
  endfunction

  function automatic comp_out_t clamp(longint v);
    if (v < 0) v = 0;
    if (v > ONE) v = ONE;
    return comp_out_t'(v);
  endfunction

  function automatic longint max3(longint a, longint b, longint c);
    longint m;
    m = a > b ? a : b;
    return m > c ? m : c;
  endfunction

  function automatic longint min3(longint a, longint b, longint c);
    longint m;
    m = a < b ? a : b;
    return m < c ? m : c;
  endfunction

  function automatic logic [OUT_W*3-1:0] hsl_of(longint r, longint g, longint b);
    longint mx, mn, diff, sum, h, s, l, num;
    h = 0;
    s = 0;
    mx = max3(r, g, b);
    // scale down by the brightest component, truncating
    if (mx > ONE) begin
      r = r * ONE / mx;
      g = g * ONE / mx;
      b = b * ONE / mx;
    end
    if (r < 0) r = 0;
    if (g < 0) g = 0;
    if (b < 0) b = 0;
    mx = max3(r, g, b);
    mn = min3(r, g, b);
    diff = mx - mn;
    sum = mx + mn;
    l = rnd_div(sum, 2);
    if (mx != mn) begin
      if (sum < ONE) s = rnd_div(diff * ONE, sum);
      else           s = rnd_div(diff * ONE, 2 * ONE - sum);
      if (mx == r)      num = g - b;
      else if (mx == g) num = 2 * diff + (b - r);
      else              num = 4 * diff + (r - g);
      if (num < 0) num += 6 * diff;
      h = rnd_div(num * ONE, 6 * diff);
      if (h >= ONE) h -= ONE;
    end
    return {clamp(l), clamp(s), clamp(h)};
  endfunction

  // hue position kept times three so the thirds stay exact
  function automatic longint hue_chan(longint v3, longint t1, longint t2);
    if (v3 > 3 * ONE) v3 -= 3 * ONE;
    if (2 * v3 < ONE) return t2 + rnd_div((t1 - t2) * 2 * v3, ONE);
    if (2 * v3 < 3 * ONE) return t1;
    if (v3 < 2 * ONE) return t2 + rnd_div((t1 - t2) * 2 * (2 * ONE - v3), ONE);
    return t2;
  endfunction

  function automatic logic [OUT_W*3-1:0] rgb_of(longint h, longint s, longint l);
    longint t1, t2, h3;
    h = h - fdiv(h, ONE) * ONE;
    if (s == 0) return {clamp(l), clamp(l), clamp(l)};
    if (2 * l < ONE) t1 = rnd_div(l * (ONE + s), ONE);
    else             t1 = (l + s) - rnd_div(l * s, ONE);
    t2 = 2 * l - t1;
    h3 = 3 * h;
    return {clamp(hue_chan(h3 + 2 * ONE, t1, t2)), clamp(hue_chan(h3, t1, t2)),
            clamp(hue_chan(h3 + ONE, t1, t2))};
  endfunction

  always @(posedge clk) begin
    longint a, b, c;
    logic [OUT_W*3-1:0] exp_px;
    if (!rst_n) begin
      cur_dir   <= DIR_RGB2HSL;
      err_count <= 0;
      pending   <= 0;
      pixel_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) cur_dir <= dir_t'(cfg_data);
      if (in_tvalid && in_tready) begin
        a = comp_in_t'(in_tdata[19:0]);
        b = comp_in_t'(in_tdata[39:20]);
        c = comp_in_t'(in_tdata[59:40]);
        if (cur_dir == DIR_RGB2HSL) pixel_q.push_back(hsl_of(a, b, c));
        else                        pixel_q.push_back(rgb_of(a, b, c));
      end
      if (out_tvalid && out_tready) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected item, actual %h", $time, out_tdata);
          err_count <= err_count + 1;
        end else begin
          exp_px = pixel_q.pop_front();
          if (out_tdata[50:0] !== exp_px || out_tdata[55:51] !== 5'd0) begin
            $display("%0t: mismatch, expected %h actual %h", $time, exp_px,
                     out_tdata);
            err_count <= err_count + 1;
          end
        end
      end
      pending <= pixel_q.size();
    end
  end
endmodule

@@ tb/sv/tb_rgb_hsl_colour_converter.sv @@
`timescale 1ns / 1ps
// Testbench top for the RGB/HSL colour converter: clock, reset, stimulus and
// verdict. Depends on rhc_pkg, the block and rhc_checker.
module tb_rgb_hsl_colour_converter;
  import rhc_pkg::*;

  localparam int LATENCY   = 39;
  localparam int WDOG_MAX  = 20000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // [19:0] first_in, [39:20] second_in, [59:40] third_in, [63:60] zero
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  // [16:0] first_out, [33:17] second_out, [50:34] third_out, [55:51] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic                   cfg_data;
  int                     err_count;
  int                     pending;
  int                     idle_cycles;
  bit                     stall_hold;  // long receiver hold-off when set

  rgb_hsl_colour_converter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  rhc_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Short gaps mostly, now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Pick a component: extremes, in-range values, or anything at all.
  function automatic logic [19:0] pick_comp();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8)  return 20'h80000;
    if (p < 16) return 20'h7FFFF;
    if (p < 24) return 20'h10000;
    if (p < 30) return 20'h0;
    if (p < 75) return 20'($urandom_range(0, 65536));
    return 20'($urandom);
  endfunction

  // Watchdog: count cycles with no handshake on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: random ready, plus a long hold-off on request.
  initial begin
    int g;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_hold) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        stall_hold = 1'b0;
      end
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one item; hold it until accepted.
  task automatic send_pixel(logic [19:0] a, logic [19:0] b, logic [19:0] c,
                            bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, c, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain outstanding results, then write the direction register.
  task automatic set_direction(dir_t d);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_set();
    send_pixel(20'h0, 20'h0, 20'h0, 0);
    send_pixel(20'h10000, 20'h10000, 20'h10000, 0);
    send_pixel(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 0);
    send_pixel(20'h80000, 20'h80000, 20'h80000, 0);
    send_pixel(20'h7FFFF, 20'h80000, 20'h0, 0);
    send_pixel(20'h10000, 20'h0, 20'h0, 0);
    send_pixel(20'h0, 20'h10000, 20'h0, 0);
    send_pixel(20'h0, 20'h0, 20'h10000, 0);
    send_pixel(20'h10000, 20'h0, 20'h00001, 0);
    send_pixel(20'h08000, 20'h10000, 20'h08000, 0);
    send_pixel(20'h0, 20'h10000, 20'h0, 0);
    send_pixel(20'h2AAAB, 20'h08000, 20'hFFFFF, 0);
  endtask

  initial begin
    int n;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_data    = 1'b0;
    stall_hold  = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    // Reset direction converts RGB to HSL.
    directed_set();
    set_direction(DIR_HSL2RGB);
    directed_set();  // grey, hue wrap and out-of-range S/L
    set_direction(DIR_RGB2HSL);
    stall_hold = 1'b1;  // fill the pipeline against a stalled receiver
    for (n = 0; n < 1600; n++) begin
      if (n % 400 == 200) set_direction(dir_t'((n / 400) % 2 == 0));
      if (n % 400 == 0 && n != 0) set_direction(DIR_RGB2HSL);
      send_pixel(pick_comp(), pick_comp(), pick_comp(), $urandom_range(0, 2) != 0);
    end
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
